[src/blr_pkg.sv]
// ----------------------------------------------------------------------------
// blr_pkg
// shared constants, command and status types for the byte-run line decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

    localparam int BYTE_W              = 8;
    localparam int LANES               = 4;
    localparam int CNT_W               = 3;
    localparam int LB_W                = 9;
    localparam int MAX_LINE_BYTES_DEF  = 256;
    localparam int TDATA_W             = 40;
    localparam int TUSER_W             = 2;
    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;

    localparam logic [LB_W-1:0]   LINE_BYTES_RST = 9'd40;
    localparam logic              MODE_RST       = 1'b1;
    localparam logic [BYTE_W-1:0] HDR_NOP        = 8'h80;

    // register index, taken from paddr[2]
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LINE = 1'b1;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_LITERAL,
        ST_REPEAT,
        ST_DRAIN
    } state_t;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_RESTART,
        DP_RAW,
        DP_HEADER,
        DP_LITERAL,
        DP_REPEAT_LOAD,
        DP_CHUNK
    } dp_op_t;

    typedef struct packed {
        logic            compressed_mode;
        logic [LB_W-1:0] line_bytes;
        logic            restart;
    } cfg_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic hdr_literal;
        logic hdr_repeat;
        logic run_ends;
        logic chunk_last;
    } dp_status_t;

endpackage

`default_nettype wire

[src/blr_cfg.sv]
// ----------------------------------------------------------------------------
// blr_cfg
// register file behind the apb port, with restart strobe on every write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blr_cfg
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [blr_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [blr_pkg::PDATA_W-1:0]  pwdata,
    output logic      [blr_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output blr_pkg::cfg_t                     cfg
);

    logic                        mode_reg;
    logic                        mode_next;
    logic [blr_pkg::LB_W-1:0]    line_bytes_reg;
    logic [blr_pkg::LB_W-1:0]    line_bytes_next;
    logic                        wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_comb
    begin
        mode_next       = mode_reg;
        line_bytes_next = line_bytes_reg;
        if (wr)
        begin
            unique case (paddr[2])
                blr_pkg::REG_MODE: mode_next       = pwdata[0];
                blr_pkg::REG_LINE: line_bytes_next = pwdata[blr_pkg::LB_W-1:0];
                default:           mode_next       = mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= blr_pkg::MODE_RST;
            line_bytes_reg <= blr_pkg::LINE_BYTES_RST;
        end
        else
        begin
            mode_reg       <= mode_next;
            line_bytes_reg <= line_bytes_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            blr_pkg::REG_MODE: prdata = {{(blr_pkg::PDATA_W-1){1'b0}}, mode_reg};
            blr_pkg::REG_LINE: prdata = {{(blr_pkg::PDATA_W-blr_pkg::LB_W){1'b0}},
                                         line_bytes_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.compressed_mode = mode_reg;
    assign cfg.line_bytes      = line_bytes_reg;
    assign cfg.restart         = wr;

endmodule

`default_nettype wire

[src/blr_ctrl.sv]
// ----------------------------------------------------------------------------
// blr_ctrl
// decode state machine: header, literal copy, repeat load and chunk drain
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blr_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire blr_pkg::cfg_t        cfg,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire blr_pkg::dp_status_t  status,
    output blr_pkg::dp_cmd_t          cmd
);

    blr_pkg::state_t state_reg;
    blr_pkg::state_t state_next;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= blr_pkg::ST_HEADER;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = blr_pkg::DP_NONE;
        s_tready   = (state_reg != blr_pkg::ST_DRAIN) && status.out_free && !cfg.restart;
        accept     = s_tvalid && s_tready;

        if (cfg.restart)
        begin
            cmd.op     = blr_pkg::DP_RESTART;
            state_next = blr_pkg::ST_HEADER;
        end
        else if (!cfg.compressed_mode)
        begin
            if (accept)
                cmd.op = blr_pkg::DP_RAW;
        end
        else
        begin
            unique case (state_reg)
                blr_pkg::ST_HEADER:
                begin
                    if (accept)
                    begin
                        cmd.op = blr_pkg::DP_HEADER;
                        if (status.hdr_literal)
                            state_next = blr_pkg::ST_LITERAL;
                        else if (status.hdr_repeat)
                            state_next = blr_pkg::ST_REPEAT;
                    end
                end
                blr_pkg::ST_LITERAL:
                begin
                    if (accept)
                    begin
                        cmd.op = blr_pkg::DP_LITERAL;
                        if (status.run_ends)
                            state_next = blr_pkg::ST_HEADER;
                    end
                end
                blr_pkg::ST_REPEAT:
                begin
                    if (accept)
                    begin
                        cmd.op     = blr_pkg::DP_REPEAT_LOAD;
                        state_next = blr_pkg::ST_DRAIN;
                    end
                end
                blr_pkg::ST_DRAIN:
                begin
                    if (status.out_free)
                    begin
                        cmd.op = blr_pkg::DP_CHUNK;
                        if (status.chunk_last)
                            state_next = blr_pkg::ST_HEADER;
                    end
                end
                default:
                begin
                    state_next = blr_pkg::ST_HEADER;
                end
            endcase
        end
    end

    a_drain_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == blr_pkg::ST_DRAIN |-> !s_tready)
        else $error("input taken while a repeat run drains");

    a_restart_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.restart |=> state_reg == blr_pkg::ST_HEADER)
        else $error("register write did not restart decoding");

    a_chunk_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == blr_pkg::DP_CHUNK |-> status.out_free)
        else $error("chunk issued into a full output register");

endmodule

`default_nettype wire

[src/blr_datapath.sv]
// ----------------------------------------------------------------------------
// blr_datapath
// run and line counters, repeat byte, chunk split and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module blr_datapath
#(
    parameter int MAX_LINE_BYTES = blr_pkg::MAX_LINE_BYTES_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire blr_pkg::cfg_t                     cfg,
    input  wire blr_pkg::dp_cmd_t                  cmd,
    output blr_pkg::dp_status_t                    status,
    input  wire logic [blr_pkg::BYTE_W-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [blr_pkg::TDATA_W-1:0]       m_tdata,
    output logic                                   m_tlast,
    output logic      [blr_pkg::TUSER_W-1:0]       m_tuser
);

    localparam int LW = $clog2(MAX_LINE_BYTES + 1);
    localparam int CW = (LW > blr_pkg::BYTE_W) ? LW : blr_pkg::BYTE_W;
    localparam int PAD_W = blr_pkg::TDATA_W - blr_pkg::LANES * blr_pkg::BYTE_W
                           - blr_pkg::CNT_W;

    // line_left of zero outside a literal run stands for a full line
    logic [blr_pkg::BYTE_W-1:0]  run_left_reg,  run_left_next;
    logic [LW-1:0]               line_left_reg, line_left_next;
    logic [blr_pkg::BYTE_W-1:0]  emit_left_reg, emit_left_next;
    logic [blr_pkg::BYTE_W-1:0]  rep_byte_reg,  rep_byte_next;
    logic                        ovr_reg,       ovr_next;

    logic                                         out_valid_reg, out_valid_next;
    logic [blr_pkg::LANES-1:0][blr_pkg::BYTE_W-1:0] out_bytes_reg, out_bytes_next;
    logic [blr_pkg::CNT_W-1:0]                    out_cnt_reg,   out_cnt_next;
    logic                                         out_last_reg,  out_last_next;
    logic                                         out_lend_reg,  out_lend_next;
    logic                                         out_ovr_reg,   out_ovr_next;

    logic [blr_pkg::LB_W-1:0]    lb_nz;
    logic [LW-1:0]               eff_line;
    logic [LW-1:0]               line_cur;
    logic [LW-1:0]               line_dec;
    logic [CW-1:0]               run_w;
    logic [CW-1:0]               line_w;
    logic [blr_pkg::CNT_W-1:0]   chunk;
    logic [blr_pkg::BYTE_W-1:0]  emit_rem;
    logic [LW-1:0]               line_rem;
    logic                        load;
    logic [blr_pkg::BYTE_W-1:0]  ld_byte;

    always_comb
    begin
        lb_nz = (cfg.line_bytes == '0) ? blr_pkg::LB_W'(1) : cfg.line_bytes;
        if (32'(lb_nz) > MAX_LINE_BYTES)
            eff_line = LW'(MAX_LINE_BYTES);
        else
            eff_line = LW'(lb_nz);
    end

    assign line_cur = (line_left_reg == '0) ? eff_line : line_left_reg;
    assign line_dec = line_cur - LW'(1);
    assign run_w    = CW'(run_left_reg);
    assign line_w   = CW'(line_left_reg);

    always_comb
    begin
        if (emit_left_reg < blr_pkg::BYTE_W'(blr_pkg::LANES))
            chunk = emit_left_reg[blr_pkg::CNT_W-1:0];
        else
            chunk = blr_pkg::CNT_W'(blr_pkg::LANES);
        emit_rem = emit_left_reg - blr_pkg::BYTE_W'(chunk);
        line_rem = line_left_reg - LW'(chunk);
    end

    always_comb
    begin
        run_left_next  = run_left_reg;
        line_left_next = line_left_reg;
        emit_left_next = emit_left_reg;
        rep_byte_next  = rep_byte_reg;
        ovr_next       = ovr_reg;
        load           = 1'b0;
        ld_byte        = s_tdata;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;
        out_lend_next  = out_lend_reg;
        out_ovr_next   = out_ovr_reg;

        unique case (cmd.op)
            blr_pkg::DP_RESTART:
            begin
                run_left_next  = '0;
                line_left_next = '0;
                emit_left_next = '0;
            end
            blr_pkg::DP_RAW:
            begin
                line_left_next = line_dec;
                load           = 1'b1;
                out_cnt_next   = blr_pkg::CNT_W'(1);
                out_last_next  = 1'b1;
                out_lend_next  = (line_dec == '0);
                out_ovr_next   = 1'b0;
            end
            blr_pkg::DP_HEADER:
            begin
                line_left_next = line_cur;
                if (!s_tdata[blr_pkg::BYTE_W-1])
                    run_left_next = s_tdata + blr_pkg::BYTE_W'(1);
                else if (s_tdata != blr_pkg::HDR_NOP)
                    run_left_next = blr_pkg::BYTE_W'(1) - s_tdata;
            end
            blr_pkg::DP_LITERAL:
            begin
                load          = 1'b1;
                out_last_next = 1'b1;
                if (line_left_reg != '0)
                begin
                    line_left_next = line_left_reg - LW'(1);
                    out_cnt_next   = blr_pkg::CNT_W'(1);
                    out_lend_next  = (line_left_reg == LW'(1));
                    out_ovr_next   = 1'b0;
                end
                else
                begin
                    out_cnt_next  = '0;
                    out_lend_next = 1'b0;
                    out_ovr_next  = 1'b1;
                end
                if (run_left_reg != '0)
                    run_left_next = run_left_reg - blr_pkg::BYTE_W'(1);
            end
            blr_pkg::DP_REPEAT_LOAD:
            begin
                rep_byte_next  = s_tdata;
                ovr_next       = (run_w > line_w);
                emit_left_next = (run_w > line_w) ? blr_pkg::BYTE_W'(line_w) : run_left_reg;
            end
            blr_pkg::DP_CHUNK:
            begin
                load           = 1'b1;
                ld_byte        = rep_byte_reg;
                emit_left_next = emit_rem;
                line_left_next = line_rem;
                out_cnt_next   = chunk;
                out_last_next  = (emit_rem == '0);
                out_lend_next  = (chunk != '0) && (line_rem == '0);
                out_ovr_next   = (emit_rem == '0) && ovr_reg;
                if (emit_rem == '0)
                    run_left_next = '0;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_bytes_next = out_bytes_reg;
        if (load)
        begin
            for (int i = 0; i < blr_pkg::LANES; i++)
            begin
                if (blr_pkg::CNT_W'(i) < out_cnt_next)
                    out_bytes_next[i] = ld_byte;
                else
                    out_bytes_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_left_reg  <= '0;
            line_left_reg <= '0;
            emit_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_left_reg  <= run_left_next;
            line_left_reg <= line_left_next;
            emit_left_reg <= emit_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rep_byte_reg  <= rep_byte_next;
        ovr_reg       <= ovr_next;
        out_bytes_reg <= out_bytes_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
        out_lend_reg  <= out_lend_next;
        out_ovr_reg   <= out_ovr_next;
    end

    assign status.out_free    = !out_valid_reg || m_tready;
    assign status.hdr_literal = !s_tdata[blr_pkg::BYTE_W-1];
    assign status.hdr_repeat  = s_tdata[blr_pkg::BYTE_W-1] && (s_tdata != blr_pkg::HDR_NOP);
    assign status.run_ends    = (run_left_reg <= blr_pkg::BYTE_W'(1));
    assign status.chunk_last  = (emit_left_reg <= blr_pkg::BYTE_W'(blr_pkg::LANES));

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_cnt_reg, out_bytes_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovr_reg, out_lend_reg};

    a_empty_beat_is_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_cnt_reg == '0 |-> out_ovr_reg)
        else $error("empty beat without overrun");

    a_line_end_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_lend_reg |-> out_cnt_reg != '0)
        else $error("line end on an empty beat");

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_cnt_reg <= blr_pkg::CNT_W'(blr_pkg::LANES))
        else $error("byte count above lane count");

endmodule

`default_nettype wire

[src/byterun1_line_decoder.sv]
// ----------------------------------------------------------------------------
// byterun1_line_decoder
// byte-run (packbits) decoder from a byte stream into raster lines
// ----------------------------------------------------------------------------
// slave stream: one compressed or raw byte per beat on s_tdata.
// master stream: up to four decoded bytes per beat with a count; m_tlast
// marks the last beat caused by an input byte, m_tuser carries line end
// and overrun. the apb port holds the mode and line length registers;
// any write restarts decoding at a header and a fresh line.
// a literal or raw byte shows on the master side in the cycle after it is
// taken. header bytes give no beat. a repeat byte is loaded first, then
// the run leaves as ceil(n/4) beats for the n bytes left after clipping,
// one a cycle while the output register is free, during which the slave
// side is held off.
// the output register lets a new byte in while its beat is being taken;
// when a beat waits with m_tready low, s_tready drops and nothing is lost.
// reset returns to header decoding, compressed mode and 40-byte lines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byterun1_line_decoder
#(
    parameter int MAX_LINE_BYTES = blr_pkg::MAX_LINE_BYTES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // data_byte
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [blr_pkg::BYTE_W-1:0]    s_tdata,
    // out_byte_0, out_byte_1, out_byte_2, out_byte_3, byte_count, zero pad
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [blr_pkg::TDATA_W-1:0]   m_tdata,
    output logic                               m_tlast,
    // line_end, overrun
    output logic      [blr_pkg::TUSER_W-1:0]   m_tuser,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [blr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [blr_pkg::PDATA_W-1:0]   pwdata,
    output logic      [blr_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    blr_pkg::cfg_t       cfg;
    blr_pkg::dp_cmd_t    cmd;
    blr_pkg::dp_status_t status;

    blr_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    blr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    blr_datapath
    #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
